// ===== rtl/core/fsa_pkg.sv =====
// ----------------------------------------------------------------------------
// fsa_pkg: free list slot allocator package
// Sizes, word formats, status codes and the records passed along the cell row.
// ----------------------------------------------------------------------------
package fsa_pkg;

	localparam int unsigned POOL_ENTRIES = 32;
	localparam int unsigned SLOT_W       = $clog2(POOL_ENTRIES);
	localparam int unsigned LINK_W       = SLOT_W + 1;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NONE_USED = 2'd2,
		ST_NOT_USED  = 2'd3
	} status_t;

	typedef struct packed {
		logic              mode;
		logic [SLOT_W-1:0] slot_index;
	} req_word_t;

	typedef struct packed {
		logic [SLOT_W-1:0] result_slot;
		status_t           status;
		logic [LINK_W-1:0] used_head;
	} rsp_word_t;

	typedef struct packed {
		logic              valid;
		logic [SLOT_W-1:0] want;
		logic              hit;
		logic [LINK_W-1:0] want_link;
		logic              prev_hit;
		logic [SLOT_W-1:0] prev;
	} token_t;

	typedef struct packed {
		logic              link_a_en;
		logic [SLOT_W-1:0] link_a_addr;
		logic [LINK_W-1:0] link_a_data;
		logic              link_b_en;
		logic [SLOT_W-1:0] link_b_addr;
		logic [LINK_W-1:0] link_b_data;
		logic              use_en;
		logic [SLOT_W-1:0] use_addr;
		logic              use_val;
	} wr_t;

	function automatic logic is_slot(logic [LINK_W-1:0] v);
		return v < LINK_W'(POOL_ENTRIES);
	endfunction

endpackage

// ===== rtl/core/fsa_stream_if.sv =====
// ----------------------------------------------------------------------------
// fsa_stream_if: valid/ready channel
// Carries one word of type T from a source to a sink.
// ----------------------------------------------------------------------------
interface fsa_stream_if #(parameter type T = logic);

	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

// ===== rtl/core/fsa_cell.sv =====
// ----------------------------------------------------------------------------
// fsa_cell: one slot of the allocator
// Holds the slot's next link and in-use flag, and updates the passing token.
// ----------------------------------------------------------------------------
module fsa_cell #(
	parameter int unsigned CELL_IDX = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  fsa_pkg::token_t tok_in,
	output fsa_pkg::token_t tok_out,
	input  fsa_pkg::wr_t    wr
);
	import fsa_pkg::*;

	localparam logic [SLOT_W-1:0] MY_IDX      = SLOT_W'(CELL_IDX);
	localparam logic [LINK_W-1:0] MY_LINK_RST = LINK_W'(CELL_IDX + 1);

	logic [LINK_W-1:0] link_q;
	logic              in_use_q;
	token_t            tok_q;
	token_t            tok_nxt;

	always_comb begin
		tok_nxt = tok_in;
		if (tok_in.want == MY_IDX) begin
			tok_nxt.hit       = in_use_q;
			tok_nxt.want_link = link_q;
		end
		if (in_use_q && link_q == {1'b0, tok_in.want}) begin
			tok_nxt.prev_hit = 1'b1;
			tok_nxt.prev     = MY_IDX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q   <= MY_LINK_RST;
			in_use_q <= 1'b0;
			tok_q    <= '0;
		end else begin
			tok_q <= tok_nxt;
			if (wr.link_a_en && wr.link_a_addr == MY_IDX) begin
				link_q <= wr.link_a_data;
			end else if (wr.link_b_en && wr.link_b_addr == MY_IDX) begin
				link_q <= wr.link_b_data;
			end
			if (wr.use_en && wr.use_addr == MY_IDX) begin
				in_use_q <= wr.use_val;
			end
		end
	end

	assign tok_out = tok_q;

	// No slot's link ever points into the free list's terminator range
	// beyond the end marker.
	a_link_range: assert property (@(posedge clk) disable iff (!arst_n)
		link_q <= LINK_W'(POOL_ENTRIES))
		else $error("fsa_cell: link beyond end marker");

	// Both link ports never target this cell in the same cycle.
	a_one_link_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr.link_a_en && wr.link_b_en && wr.link_a_addr == MY_IDX
			&& wr.link_b_addr == MY_IDX))
		else $error("fsa_cell: two link writes to one slot");

	// A free only clears a slot that the passing token reported as in use.
	a_clear_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.use_en && !wr.use_val && wr.use_addr == MY_IDX) |-> in_use_q)
		else $error("fsa_cell: clearing a slot that is not in use");

endmodule

// ===== rtl/core/free_list_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// free_list_slot_allocator: linked free list slot allocator
// Pool of slots kept as a free list and an in-use list over one link store,
// held in a row of cells that a lookup token walks one cell per cycle.
// ----------------------------------------------------------------------------
//   Channel | Dir | Word fields
//   req     | in  | mode, slot_index
//   rsp     | out | result_slot, status, used_head
//
// The response word is offered once its request has been looked up: the accepting
// edge loads the first cell, the token then passes through each further cell, and
// the result is captured and then written back. The next request can be accepted
// once the previous one has been written back. A held response does not block
// acceptance, but write-back waits until the response register is empty
// or is being emptied. After reset all slots are free.
// ----------------------------------------------------------------------------
module free_list_slot_allocator (
	input logic         clk,
	input logic         arst_n,
	fsa_stream_if.sink   req,
	fsa_stream_if.source rsp
);
	import fsa_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_WRITE
	} state_t;

	state_t            state_q;
	logic              mode_q;
	logic [LINK_W-1:0] free_head_q;
	logic [LINK_W-1:0] used_head_q;
	token_t            res_q;
	logic              rsp_valid_q;
	rsp_word_t         rsp_data_q;

	token_t            tok [0:POOL_ENTRIES];
	wr_t               wr;
	req_word_t         req_word;
	logic              req_take;
	logic              rsp_go;
	logic              alloc_ok;
	logic              free_ok;
	logic [LINK_W-1:0] used_head_nxt;
	logic [LINK_W-1:0] free_head_nxt;
	status_t           status_nxt;

	assign req_word  = req.data;
	assign req.ready = (state_q == S_IDLE);
	assign req_take  = req.valid && req.ready;

	always_comb begin
		tok[0]       = '0;
		tok[0].valid = req_take;
		tok[0].want  = (req_word.mode == MODE_ALLOC) ? free_head_q[SLOT_W-1:0]
			: req_word.slot_index;
	end

	for (genvar i = 0; i < POOL_ENTRIES; i++) begin : g_cell
		fsa_cell #(.CELL_IDX(i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tok_in (tok[i]),
			.tok_out(tok[i+1]),
			.wr     (wr)
		);
	end

	assign rsp_go   = (state_q == S_WRITE) && (!rsp_valid_q || rsp.ready);
	assign alloc_ok = (mode_q == MODE_ALLOC) && is_slot(free_head_q);
	assign free_ok  = (mode_q == MODE_FREE) && is_slot(used_head_q) && res_q.hit;

	always_comb begin
		used_head_nxt = used_head_q;
		free_head_nxt = free_head_q;
		if (mode_q == MODE_ALLOC) begin
			status_nxt = alloc_ok ? ST_OK : ST_EMPTY;
		end else if (!is_slot(used_head_q)) begin
			status_nxt = ST_NONE_USED;
		end else begin
			status_nxt = res_q.hit ? ST_OK : ST_NOT_USED;
		end
		if (alloc_ok) begin
			free_head_nxt = res_q.want_link;
			used_head_nxt = {1'b0, res_q.want};
		end else if (free_ok) begin
			free_head_nxt = {1'b0, res_q.want};
			if (!res_q.prev_hit) begin
				used_head_nxt = res_q.want_link;
			end
		end
	end

	always_comb begin
		wr             = '0;
		wr.link_a_addr = res_q.want;
		wr.link_a_data = alloc_ok ? used_head_q : free_head_q;
		wr.link_a_en   = rsp_go && (alloc_ok || free_ok);
		wr.link_b_addr = res_q.prev;
		wr.link_b_data = res_q.want_link;
		wr.link_b_en   = rsp_go && free_ok && res_q.prev_hit;
		wr.use_addr    = res_q.want;
		wr.use_val     = alloc_ok;
		wr.use_en      = rsp_go && (alloc_ok || free_ok);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= MODE_ALLOC;
			free_head_q <= '0;
			used_head_q <= LINK_W'(POOL_ENTRIES);
			res_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_data_q  <= '0;
		end else begin
			if (rsp_valid_q && rsp.ready && !rsp_go) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_take) begin
						mode_q  <= req_word.mode;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (tok[POOL_ENTRIES].valid) begin
						res_q   <= tok[POOL_ENTRIES];
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (rsp_go) begin
						free_head_q            <= free_head_nxt;
						used_head_q            <= used_head_nxt;
						rsp_valid_q            <= 1'b1;
						rsp_data_q.status      <= status_nxt;
						rsp_data_q.used_head   <= used_head_nxt;
						rsp_data_q.result_slot <= (status_nxt == ST_OK) ? res_q.want : '0;
						state_q                <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	// The token leaves the row only while a request is being looked up.
	a_token_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tok[POOL_ENTRIES].valid |-> state_q == S_SCAN)
		else $error("free_list_slot_allocator: token outside lookup");

	// The two list heads only coincide when both lists would be empty.
	a_heads_apart: assert property (@(posedge clk) disable iff (!arst_n)
		free_head_q != used_head_q)
		else $error("free_list_slot_allocator: list heads coincide");

	// A successful allocation leaves the allocated slot at the in-use head.
	a_alloc_head: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_go && alloc_ok) |=> used_head_q == {1'b0, rsp_data_q.result_slot})
		else $error("free_list_slot_allocator: allocated slot not at head");

	// An error response names no slot.
	a_error_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_data_q.status != ST_OK) |-> rsp_data_q.result_slot == '0)
		else $error("free_list_slot_allocator: error response names a slot");

endmodule
